### rtl/hog_cell_orientation_histogram_top_assert.svh
// Assertion macros used by the orientation histogram top level.
`ifndef HOG_CELL_ORIENTATION_HISTOGRAM_TOP_ASSERT_SVH
`define HOG_CELL_ORIENTATION_HISTOGRAM_TOP_ASSERT_SVH

// Checked property, disabled while reset is high.
`define HOG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define HOG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hog_pkg.sv
// Package with widths and constants of the orientation histogram.
`default_nettype none

package hog_pkg;

   // Field widths.
   localparam int unsigned MAG_W  = 8;
   localparam int unsigned DIR_W  = 8;
   localparam int unsigned BIN_W  = 4;
   localparam int unsigned SUM_W  = 16;
   localparam int unsigned R_W    = 5;
   localparam int unsigned PROD_W = 13;

   // Binning constants.
   localparam int unsigned NUM_BINS  = 9;
   localparam int unsigned BIN_DEG   = 20;
   localparam logic [DIR_W-1:0] DIR_MAX  = 8'd179;
   localparam logic [BIN_W-1:0] LAST_BIN = 4'd8;

   // Reciprocal of 20: floor(x / 20) == (x * RECIP) >> RECIP_SHIFT for x < 8192.
   localparam int unsigned RECIP       = 3277;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned RECIP_W     = 25;

   // Default cell length in pixels.
   localparam int unsigned CELL_PIXELS_DEF = 64;

   typedef logic [SUM_W-1:0] sum_type;

endpackage

`default_nettype wire

### rtl/hog_cell_orientation_histogram_top.sv
// Top level of the nine-bin HOG cell orientation histogram.
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   magnitude, direction, cell_end
//   rsp       out         rsp_valid/rsp_stall   bin_index, bin_sum, last
//
// One pixel is taken per cycle while req_stall is low; each pixel passes an
// input register and a weight register and is added into two bin accumulators.
// The last pixel of a cell copies the nine sums into an output buffer, which drains
// one bin per cycle while rsp_stall is low; the first bin follows the buffer load.
// A cell that closes while the buffer still drains holds the input with req_stall.
// Synchronous reset clears the valid flags, the pixel count and the accumulators.
`default_nettype none

`include "hog_cell_orientation_histogram_top_assert.svh"

module hog_cell_orientation_histogram_top #(
   parameter int unsigned CELL_PIXELS = hog_pkg::CELL_PIXELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hog_pkg::MAG_W-1:0]   req_magnitude,
   input  logic [hog_pkg::DIR_W-1:0]   req_direction,
   input  logic                        req_cell_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hog_pkg::BIN_W-1:0]   rsp_bin_index,
   output logic [hog_pkg::SUM_W-1:0]   rsp_bin_sum,
   output logic                        rsp_last
);
   import hog_pkg::*;

   localparam int unsigned CNT_W = (CELL_PIXELS > 1) ? $clog2(CELL_PIXELS) : 1;

   // Pixel count and input stage.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [MAG_W-1:0]  s1_mag_ff, s1_mag_in;
   logic [DIR_W-1:0]  s1_dir_ff, s1_dir_in;
   logic              s1_close_ff, s1_close_in;

   // Weight stage.
   logic              s2_valid_ff, s2_valid_in;
   logic [MAG_W-1:0]  s2_mag_ff, s2_mag_in;
   logic [PROD_W-1:0] s2_x_ff, s2_x_in;
   logic [BIN_W-1:0]  s2_base_ff, s2_base_in;
   logic [BIN_W-1:0]  s2_next_ff, s2_next_in;
   logic              s2_close_ff, s2_close_in;

   // Accumulators, output buffer and drain counter.
   sum_type           acc_ff [NUM_BINS];
   sum_type           acc_in [NUM_BINS];
   sum_type           buf_ff [NUM_BINS];
   sum_type           buf_in [NUM_BINS];
   logic              emit_ff, emit_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;

   logic              req_acc, rsp_acc, buf_free, s2_hold, load_buf, cell_close;
   logic [DIR_W-1:0]  dir_sat, thr;
   logic [BIN_W-1:0]  base, next;
   logic [R_W-1:0]    r;
   logic [RECIP_W-1:0] recip_prod;
   logic [MAG_W-1:0]  w_hi, w_lo;
   logic              exact;
   sum_type           sum [NUM_BINS];

   // Handshake and flow control.
   assign rsp_acc   = emit_ff && !rsp_stall;
   assign buf_free  = !emit_ff || (!rsp_stall && (idx_ff == LAST_BIN));
   assign s2_hold   = s2_valid_ff && s2_close_ff && !buf_free;
   assign load_buf  = s2_valid_ff && s2_close_ff && buf_free;
   assign req_stall = s1_valid_ff && s2_hold;
   assign req_acc   = req_valid && !req_stall;

   // A cell closes on its marked last pixel or when the count runs out.
   assign cell_close = req_cell_end || (cnt_ff == CNT_W'(CELL_PIXELS - 1));

   // Input stage register and pixel count.
   always_comb begin
      cnt_in      = cnt_ff;
      s1_mag_in   = s1_mag_ff;
      s1_dir_in   = s1_dir_ff;
      s1_close_in = s1_close_ff;
      s1_valid_in = s2_hold ? (s1_valid_ff || req_acc) : req_acc;
      if (req_acc) begin
         cnt_in      = cell_close ? '0 : cnt_ff + CNT_W'(1);
         s1_mag_in   = req_magnitude;
         s1_dir_in   = req_direction;
         s1_close_in = cell_close;
      end
   end

   // Saturate the direction and split it into base bin and offset.
   always_comb begin
      dir_sat = (s1_dir_ff > DIR_MAX) ? DIR_MAX : s1_dir_ff;
      base    = '0;
      thr     = '0;
      for (int k = 1; k < NUM_BINS; k++) begin
         if (dir_sat >= DIR_W'(k * BIN_DEG)) begin
            base = BIN_W'(k);
            thr  = DIR_W'(k * BIN_DEG);
         end
      end
      r    = R_W'(dir_sat - thr);
      next = (base == LAST_BIN) ? '0 : base + BIN_W'(1);
   end

   // Weight stage register; the product mag * r sets the upper share.
   always_comb begin
      s2_valid_in = s2_hold ? 1'b1 : s1_valid_ff;
      s2_mag_in   = s2_mag_ff;
      s2_x_in     = s2_x_ff;
      s2_base_in  = s2_base_ff;
      s2_next_in  = s2_next_ff;
      s2_close_in = s2_close_ff;
      if (!s2_hold) begin
         s2_mag_in   = s1_mag_ff;
         s2_x_in     = PROD_W'(s1_mag_ff) * PROD_W'(r);
         s2_base_in  = base;
         s2_next_in  = next;
         s2_close_in = s1_close_ff;
      end
   end

   // Upper share is floor(x / 20); the lower share is mag minus its ceiling.
   always_comb begin
      recip_prod = RECIP_W'(s2_x_ff) * RECIP_W'(RECIP);
      w_hi       = recip_prod[RECIP_SHIFT +: MAG_W];
      exact      = ((PROD_W'(w_hi) * PROD_W'(BIN_DEG)) == s2_x_ff);
      w_lo       = s2_mag_ff - w_hi - MAG_W'(!exact);
   end

   // Per-bin sums including the current pixel.
   always_comb begin
      for (int i = 0; i < NUM_BINS; i++) begin
         sum[i] = acc_ff[i]
                + ((s2_base_ff == BIN_W'(i)) ? SUM_W'(w_lo) : '0)
                + ((s2_next_ff == BIN_W'(i)) ? SUM_W'(w_hi) : '0);
      end
   end

   // Accumulator update, cleared when the cell closes.
   always_comb begin
      for (int i = 0; i < NUM_BINS; i++) begin
         acc_in[i] = acc_ff[i];
         buf_in[i] = load_buf ? sum[i] : buf_ff[i];
         if (s2_valid_ff && !s2_hold) begin
            acc_in[i] = s2_close_ff ? '0 : sum[i];
         end
      end
   end

   // Output buffer drain.
   always_comb begin
      emit_in = emit_ff;
      idx_in  = idx_ff;
      if (load_buf) begin
         emit_in = 1'b1;
         idx_in  = '0;
      end else if (rsp_acc) begin
         emit_in = (idx_ff != LAST_BIN);
         idx_in  = idx_ff + BIN_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         emit_ff     <= 1'b0;
         idx_ff      <= '0;
         for (int i = 0; i < NUM_BINS; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         emit_ff     <= emit_in;
         idx_ff      <= idx_in;
         acc_ff      <= acc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_mag_ff   <= s1_mag_in;
      s1_dir_ff   <= s1_dir_in;
      s1_close_ff <= s1_close_in;
      s2_mag_ff   <= s2_mag_in;
      s2_x_ff     <= s2_x_in;
      s2_base_ff  <= s2_base_in;
      s2_next_ff  <= s2_next_in;
      s2_close_ff <= s2_close_in;
      buf_ff      <= buf_in;
   end

   // Result item outputs.
   assign rsp_valid     = emit_ff;
   assign rsp_bin_index = idx_ff;
   assign rsp_bin_sum   = buf_ff[idx_ff];
   assign rsp_last      = (idx_ff == LAST_BIN);

   // Checks on reset, the drain and the cell count.
   `HOG_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "results after reset")
   `HOG_ASSERT(a_hold_only_draining, clock, reset, s2_hold |-> rsp_valid,
      "input held with no drain")
   `HOG_ASSERT(a_load_starts_bin0, clock, reset,
      load_buf |=> (rsp_valid && (rsp_bin_index == '0)), "cell drain not at bin zero")
   `HOG_ASSERT(a_drain_ends, clock, reset,
      (rsp_valid && !rsp_stall && rsp_last && !load_buf) |=> !rsp_valid,
      "results past the last bin")
   `HOG_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNT_W'(CELL_PIXELS - 1),
      "pixel count past cell length")

endmodule

`default_nettype wire
